FILE: sv/kinematic_bicycle_step_top_assert.svh
// Assertion macros for the kinematic bicycle step block.
`ifndef KINEMATIC_BICYCLE_STEP_TOP_ASSERT_SVH
`define KINEMATIC_BICYCLE_STEP_TOP_ASSERT_SVH

// Check a condition at every clock edge outside reset.
`define KBS_ASSERT_COMB(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Check that a trigger is followed by a condition in the next cycle.
`define KBS_ASSERT_NEXT(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) else $error(msg);

`endif

FILE: sv/kbs_pkg.sv
`timescale 1ns / 1ps

package kbs_pkg;

  // Action codes carried in tuser
  localparam logic [1:0] ACT_ADVANCE = 2'd0;
  localparam logic [1:0] ACT_CONTROL = 2'd1;
  localparam logic [1:0] ACT_RESTART = 2'd2;

  // Configuration register indexes
  localparam logic [2:0] REG_START_X       = 3'd0;
  localparam logic [2:0] REG_START_Y       = 3'd1;
  localparam logic [2:0] REG_START_SPEED   = 3'd2;
  localparam logic [2:0] REG_START_HEADING = 3'd3;
  localparam logic [2:0] REG_START_ACCEL   = 3'd4;
  localparam logic [2:0] REG_INV_WHEELBASE = 3'd5;

  // Angles in radians scaled by 2^24
  localparam logic signed [27:0] COR_PI      = 28'sd52707179;
  localparam logic signed [27:0] COR_HALF_PI = 28'sd26353589;
  localparam logic signed [35:0] WRAP_PI     = 36'sd52707179;
  localparam logic signed [35:0] WRAP_TWO_PI = 36'sd105414358;

  // CORDIC start value: inverse gain in Q30
  localparam int CORDIC_GAIN_Q30 = 652032874;

  localparam logic [22:0]        SPEED_MAX = 23'd6553600;
  localparam logic signed [17:0] STEER_MAX = 18'sd65536;
  localparam logic [17:0]        IWB_RESET = 18'd23406;

  // Arctangent of 2^-i, radians scaled by 2^24
  function automatic logic [23:0] atan_entry(input logic [4:0] idx);
    logic [23:0] val;
    case (idx)
      5'd0:  val = 24'd13176795;
      5'd1:  val = 24'd7778716;
      5'd2:  val = 24'd4110060;
      5'd3:  val = 24'd2086331;
      5'd4:  val = 24'd1047214;
      5'd5:  val = 24'd524117;
      5'd6:  val = 24'd262123;
      5'd7:  val = 24'd131069;
      5'd8:  val = 24'd65536;
      5'd9:  val = 24'd32768;
      5'd10: val = 24'd16384;
      5'd11: val = 24'd8192;
      5'd12: val = 24'd4096;
      5'd13: val = 24'd2048;
      5'd14: val = 24'd1024;
      5'd15: val = 24'd512;
      5'd16: val = 24'd256;
      5'd17: val = 24'd128;
      5'd18: val = 24'd64;
      5'd19: val = 24'd32;
      5'd20: val = 24'd16;
      5'd21: val = 24'd8;
      5'd22: val = 24'd4;
      5'd23: val = 24'd2;
      default: val = 24'd0;
    endcase
    return val;
  endfunction

endpackage

FILE: sv/kbs_cordic.sv
`timescale 1ns / 1ps

// Rotation-mode CORDIC, one micro-rotation per cycle.
module kbs_cordic #(
  parameter int STEPS     = 16,
  parameter int FRAC_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic signed [27:0]         angle,
  output logic                       done,
  output logic signed [FRAC_BITS+2:0] cos_out,
  output logic signed [FRAC_BITS+2:0] sin_out
);

  localparam int CW = FRAC_BITS + 3;
  localparam int IW = $clog2(STEPS + 1);
  localparam logic signed [CW-1:0] X0 = CW'(kbs_pkg::CORDIC_GAIN_Q30 >> (30 - FRAC_BITS));

  logic signed [CW-1:0] x;
  logic signed [CW-1:0] y;
  logic signed [27:0]   z;
  logic                 flip;
  logic                 busy;
  logic [IW-1:0]        cnt;
  logic signed [27:0]   step_ang;

  assign step_ang = 28'(kbs_pkg::atan_entry(5'(cnt)));

  // Fold the angle into the right half plane, then rotate
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        x    <= X0;
        y    <= '0;
        if (angle > kbs_pkg::COR_HALF_PI) begin
          z    <= angle - kbs_pkg::COR_PI;
          flip <= 1'b1;
        end else if (angle < -kbs_pkg::COR_HALF_PI) begin
          z    <= angle + kbs_pkg::COR_PI;
          flip <= 1'b1;
        end else begin
          z    <= angle;
          flip <= 1'b0;
        end
      end else if (busy) begin
        if (z >= 0) begin
          x <= x - (y >>> cnt);
          y <= y + (x >>> cnt);
          z <= z - step_ang;
        end else begin
          x <= x + (y >>> cnt);
          y <= y - (x >>> cnt);
          z <= z + step_ang;
        end
        cnt <= cnt + 1'b1;
        if (cnt == IW'(STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign cos_out = flip ? -x : x;
  assign sin_out = flip ? -y : y;

endmodule

FILE: sv/kbs_div.sv
`timescale 1ns / 1ps

// Restoring unsigned divider, one quotient bit per cycle.
module kbs_div #(
  parameter int NW = 34,
  parameter int DW = 18
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [NW-1:0] quot
);

  localparam int KW = $clog2(NW + 1);

  logic [DW:0]   rem;
  logic [DW-1:0] d;
  logic          busy;
  logic [KW-1:0] cnt;
  logic [DW:0]   rem_sh;
  logic [DW:0]   diff;

  assign rem_sh = {rem[DW-1:0], quot[NW-1]};
  assign diff   = rem_sh - {1'b0, d};

  // Shift in one numerator bit and try the subtract
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        d    <= den;
        quot <= num;
      end else if (busy) begin
        if (!diff[DW]) begin
          rem  <= diff;
          quot <= {quot[NW-2:0], 1'b1};
        end else begin
          rem  <= rem_sh;
          quot <= {quot[NW-2:0], 1'b0};
        end
        cnt <= cnt + 1'b1;
        if (cnt == KW'(NW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: sv/kinematic_bicycle_step_top.sv
`timescale 1ns / 1ps

// Kinematic bicycle vehicle model, one Euler step per advance item.
// Input items arrive on s_axis (action in tuser); every item returns one result
// item on m_axis with the whole vehicle state after that item.
// Configuration (start state, inverse wheel base) is written through cfg_we,
// cfg_index and cfg_data; the user must write it only while the block is idle,
// which the block itself does not enforce; writes take effect at once.
// An advance item runs through two passes of the iterative CORDIC (heading,
// then steering angle), the bit-serial divider for the steering tangent,
// eight passes through the one shared multiplier and the position update plus
// an eight-step heading wrap. A restart result passes through the heading wrap;
// a set-control result goes straight to the output.
// One item is in work at a time: s_axis_tready is high only while idle, so the
// block takes no new item until the last result has been taken.
// The result stays on m_axis until taken; while the receiver stalls the block
// holds it and accepts no new item.
// Reset clears the vehicle state to zero and the configuration to its defaults.
module kinematic_bicycle_step_top #(
  parameter int CORDIC_STEPS = 16,
  parameter int FRAC_BITS    = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // time_step[16:0], command_accel[38:17], command_steer[56:39], zero pad
  input  logic [63:0]  s_axis_tdata,
  // action[1:0]
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // pos_x[31:0], pos_y[63:32], speed[86:64], heading[113:87], accel[135:114],
  // steer[153:136], zero pad
  output logic [159:0] m_axis_tdata,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  localparam int CW = FRAC_BITS + 3;
  localparam int DW = FRAC_BITS + 2;
  localparam int NW = 2 * FRAC_BITS + 2;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_COR_H = 4'd1;
  localparam logic [3:0] S_COR_S = 4'd2;
  localparam logic [3:0] S_DIV   = 4'd3;
  localparam logic [3:0] S_MUL_A = 4'd4;
  localparam logic [3:0] S_MUL_B = 4'd5;
  localparam logic [3:0] S_UPD   = 4'd6;
  localparam logic [3:0] S_WRAP  = 4'd7;
  localparam logic [3:0] S_OUT   = 4'd8;

  // Multiply steps
  localparam logic [2:0] OP_XA = 3'd0;
  localparam logic [2:0] OP_XB = 3'd1;
  localparam logic [2:0] OP_YA = 3'd2;
  localparam logic [2:0] OP_YB = 3'd3;
  localparam logic [2:0] OP_HA = 3'd4;
  localparam logic [2:0] OP_HB = 3'd5;
  localparam logic [2:0] OP_HC = 3'd6;
  localparam logic [2:0] OP_V  = 3'd7;

  localparam logic signed [35:0] POS_MAX = 36'sd2147483647;
  localparam logic signed [35:0] POS_MIN = -36'sd2147483648;

  // Configuration
  logic signed [31:0] start_x;
  logic signed [31:0] start_y;
  logic [22:0]        start_speed;
  logic signed [26:0] start_heading;
  logic signed [21:0] start_accel;
  logic [17:0]        inverse_wheel_base;

  // Vehicle state
  logic signed [31:0] position_x;
  logic signed [31:0] position_y;
  logic [22:0]        speed_reg;
  logic signed [26:0] heading_reg;
  logic signed [21:0] accel_reg;
  logic signed [17:0] steer_reg;

  logic [3:0]         state;
  logic [16:0]        dt;
  logic               cor_start;
  logic               div_start;
  logic               tan_neg;
  logic [2:0]         op;
  logic [2:0]         wrap_k;
  logic signed [35:0] wrap_r;
  logic signed [CW-1:0] ch;
  logic signed [CW-1:0] sh;
  logic signed [CW-1:0] tn;
  logic signed [63:0] prod;
  logic signed [35:0] tmp;
  logic signed [35:0] dx;
  logic signed [35:0] dy;
  logic signed [35:0] dh;
  logic signed [35:0] dv;

  // Item fields
  logic [1:0]         in_action;
  logic [16:0]        in_time_step;
  logic signed [21:0] in_accel;
  logic signed [17:0] in_steer;

  assign in_action    = s_axis_tuser;
  assign in_time_step = s_axis_tdata[16:0];
  assign in_accel     = s_axis_tdata[38:17];
  assign in_steer     = s_axis_tdata[56:39];

  // Shared units
  logic               cor_done;
  logic signed [CW-1:0] cor_cos;
  logic signed [CW-1:0] cor_sin;
  logic signed [27:0] cor_angle;
  logic               div_done;
  logic [NW-1:0]      div_quot;
  logic [CW-1:0]      ss_mag;
  logic [NW-1:0]      div_num;
  logic [DW-1:0]      div_den;

  assign cor_angle = (state == S_COR_H) ? 28'(heading_reg) : (28'(steer_reg) <<< 8);
  assign ss_mag    = cor_sin[CW-1] ? CW'(-cor_sin) : CW'(cor_sin);
  assign div_num   = NW'(ss_mag) << FRAC_BITS;
  assign div_den   = (cor_cos <= 0) ? DW'(1) : cor_cos[DW-1:0];

  kbs_cordic #(
    .STEPS     (CORDIC_STEPS),
    .FRAC_BITS (FRAC_BITS)
  ) u_cordic (
    .clk     (clk),
    .rst     (rst),
    .start   (cor_start),
    .angle   (cor_angle),
    .done    (cor_done),
    .cos_out (cor_cos),
    .sin_out (cor_sin)
  );

  kbs_div #(
    .NW (NW),
    .DW (DW)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  // Select multiplier operands and result shift for each step
  logic signed [31:0] mul_a;
  logic signed [31:0] mul_b;
  logic signed [63:0] prod_sh;
  logic signed [31:0] dt_s;

  assign dt_s = 32'($signed({1'b0, dt}));

  always_comb begin
    mul_a   = 32'(tmp);
    mul_b   = dt_s;
    prod_sh = prod >>> 16;
    case (op)
      OP_XA: begin
        mul_a   = 32'($signed({1'b0, speed_reg}));
        mul_b   = 32'(ch);
        prod_sh = prod >>> FRAC_BITS;
      end
      OP_YA: begin
        mul_a   = 32'($signed({1'b0, speed_reg}));
        mul_b   = 32'(sh);
        prod_sh = prod >>> FRAC_BITS;
      end
      OP_HA: begin
        mul_a   = 32'($signed({1'b0, speed_reg}));
        mul_b   = 32'(tn);
        prod_sh = prod >>> FRAC_BITS;
      end
      OP_HB: begin
        mul_b = 32'($signed({1'b0, inverse_wheel_base}));
      end
      OP_HC: begin
        prod_sh = prod >>> 8;
      end
      OP_V: begin
        mul_a = 32'(accel_reg);
      end
      default: begin
      end
    endcase
  end

  // Position, speed and heading update terms
  logic signed [35:0] sum_x;
  logic signed [35:0] sum_y;
  logic signed [35:0] sum_v;
  logic signed [35:0] wrap_in;
  logic signed [35:0] wrap_fix;
  logic signed [35:0] wrap_sub;
  logic signed [35:0] wrap_r_next;

  assign sum_x = 36'(position_x) + dx;
  assign sum_y = 36'(position_y) + dy;
  assign sum_v = 36'($signed({1'b0, speed_reg})) + dv;

  assign wrap_in  = ((state == S_UPD) ? (36'(heading_reg) + dh) : 36'(start_heading))
                    + kbs_pkg::WRAP_PI;
  assign wrap_fix = (wrap_in < 0) ? (wrap_in + (kbs_pkg::WRAP_TWO_PI <<< 8)) : wrap_in;
  assign wrap_sub = wrap_r - (kbs_pkg::WRAP_TWO_PI <<< wrap_k);
  assign wrap_r_next = (wrap_sub >= 0) ? wrap_sub : wrap_r;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      start_x            <= '0;
      start_y            <= '0;
      start_speed        <= '0;
      start_heading      <= '0;
      start_accel        <= '0;
      inverse_wheel_base <= kbs_pkg::IWB_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        kbs_pkg::REG_START_X:       start_x            <= cfg_data;
        kbs_pkg::REG_START_Y:       start_y            <= cfg_data;
        kbs_pkg::REG_START_SPEED:   start_speed        <= cfg_data[22:0];
        kbs_pkg::REG_START_HEADING: start_heading      <= cfg_data[26:0];
        kbs_pkg::REG_START_ACCEL:   start_accel        <= cfg_data[21:0];
        kbs_pkg::REG_INV_WHEELBASE: inverse_wheel_base <= cfg_data[17:0];
        default: begin
        end
      endcase
    end
  end

  // Sequence one item through the shared units
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      cor_start   <= 1'b0;
      div_start   <= 1'b0;
      op          <= OP_XA;
      wrap_k      <= '0;
      position_x  <= '0;
      position_y  <= '0;
      speed_reg   <= '0;
      heading_reg <= '0;
      accel_reg   <= '0;
      steer_reg   <= '0;
    end else begin
      cor_start <= 1'b0;
      div_start <= 1'b0;
      case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            case (in_action)
              kbs_pkg::ACT_ADVANCE: begin
                dt        <= in_time_step;
                cor_start <= 1'b1;
                state     <= S_COR_H;
              end
              kbs_pkg::ACT_CONTROL: begin
                accel_reg <= in_accel;
                if (in_steer > kbs_pkg::STEER_MAX) begin
                  steer_reg <= kbs_pkg::STEER_MAX;
                end else if (in_steer < -kbs_pkg::STEER_MAX) begin
                  steer_reg <= -kbs_pkg::STEER_MAX;
                end else begin
                  steer_reg <= in_steer;
                end
                state <= S_OUT;
              end
              kbs_pkg::ACT_RESTART: begin
                position_x <= start_x;
                position_y <= start_y;
                speed_reg  <= (start_speed > kbs_pkg::SPEED_MAX) ? kbs_pkg::SPEED_MAX
                                                                 : start_speed;
                accel_reg  <= start_accel;
                steer_reg  <= '0;
                wrap_r     <= wrap_fix;
                wrap_k     <= 3'd7;
                state      <= S_WRAP;
              end
              default: state <= S_OUT;
            endcase
          end
        end
        S_COR_H: begin
          if (cor_done) begin
            ch        <= cor_cos;
            sh        <= cor_sin;
            cor_start <= 1'b1;
            state     <= S_COR_S;
          end
        end
        S_COR_S: begin
          if (cor_done) begin
            tan_neg   <= cor_sin[CW-1];
            div_start <= 1'b1;
            state     <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            tn    <= tan_neg ? -CW'(div_quot) : CW'(div_quot);
            op    <= OP_XA;
            state <= S_MUL_A;
          end
        end
        S_MUL_A: begin
          prod  <= mul_a * mul_b;
          state <= S_MUL_B;
        end
        S_MUL_B: begin
          case (op)
            OP_XB:   dx  <= prod_sh[35:0];
            OP_YB:   dy  <= prod_sh[35:0];
            OP_HC:   dh  <= prod_sh[35:0];
            OP_V:    dv  <= prod_sh[35:0];
            default: tmp <= prod_sh[35:0];
          endcase
          op    <= op + 1'b1;
          state <= (op == OP_V) ? S_UPD : S_MUL_A;
        end
        S_UPD: begin
          if (sum_x > POS_MAX) position_x <= POS_MAX[31:0];
          else if (sum_x < POS_MIN) position_x <= POS_MIN[31:0];
          else position_x <= sum_x[31:0];
          if (sum_y > POS_MAX) position_y <= POS_MAX[31:0];
          else if (sum_y < POS_MIN) position_y <= POS_MIN[31:0];
          else position_y <= sum_y[31:0];
          if (sum_v <= 0) begin
            speed_reg <= '0;
            if (accel_reg < 0) accel_reg <= '0;
          end else if (sum_v > 36'(kbs_pkg::SPEED_MAX)) begin
            speed_reg <= kbs_pkg::SPEED_MAX;
          end else begin
            speed_reg <= sum_v[22:0];
          end
          wrap_r <= wrap_fix;
          wrap_k <= 3'd7;
          state  <= S_WRAP;
        end
        S_WRAP: begin
          wrap_r <= wrap_r_next;
          wrap_k <= wrap_k - 1'b1;
          if (wrap_k == 3'd0) begin
            heading_reg <= 27'(wrap_r_next - kbs_pkg::WRAP_PI);
            state       <= S_OUT;
          end
        end
        S_OUT: begin
          if (m_axis_tready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign s_axis_tready = (state == S_IDLE);
  assign m_axis_tvalid = (state == S_OUT);
  assign m_axis_tdata  = {6'd0, steer_reg, accel_reg, heading_reg, speed_reg,
                          position_y, position_x};

endmodule

FILE: sv/kbs_checker.sv
`timescale 1ns / 1ps
`include "kinematic_bicycle_step_top_assert.svh"

// Port-level checks on the kinematic bicycle step block.
module kbs_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [159:0] m_axis_tdata
);

  // No item is taken while a result waits
  `KBS_ASSERT_COMB(a_busy_no_accept, !(m_axis_tvalid && s_axis_tready), "item taken while result pending")

  // A stalled result holds
  `KBS_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")

  // Ready again right after delivery
  `KBS_ASSERT_NEXT(a_ready_after_out, m_axis_tvalid && m_axis_tready, s_axis_tready, "not ready after delivery")

  // Speed within its limit
  `KBS_ASSERT_COMB(a_speed_range, !m_axis_tvalid || (m_axis_tdata[86:64] <= kbs_pkg::SPEED_MAX), "speed out of range")

  // Steering angle within one radian
  `KBS_ASSERT_COMB(a_steer_range, !m_axis_tvalid || (($signed(m_axis_tdata[153:136]) <= kbs_pkg::STEER_MAX) && ($signed(m_axis_tdata[153:136]) >= -kbs_pkg::STEER_MAX)), "steer out of range")

endmodule

bind kinematic_bicycle_step_top kbs_checker u_kbs_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

FILE: tb/kinematic_bicycle_step_top_test.sv
`timescale 1ns / 1ps

module kinematic_bicycle_step_top_test;

  localparam int  ROT_STEPS   = 16;
  localparam int  FRAC        = 16;
  localparam longint HALF_TURN = 52707179;
  localparam longint FULL_TURN = 105414358;
  localparam longint QUARTER   = 26353589;
  localparam longint X_MAX     = 64'sd2147483647;
  localparam longint X_MIN     = -64'sd2147483648;
  localparam int  STALL_LIMIT = 3000;
  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam longint ARC_TAB [0:15] = '{13176795, 7778716, 4110060, 2086331, 1047214,
    524117, 262123, 131069, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512};

  typedef struct {
    logic [31:0] px;
    logic [31:0] py;
    logic [22:0] spd;
    logic [26:0] hdg;
    logic [21:0] acc;
    logic [17:0] str;
  } vehicle_state_t;

  typedef struct {
    logic [1:0]     act;
    logic [16:0]    dt;
    logic [21:0]    acc;
    logic [17:0]    str;
    bit             known;
    vehicle_state_t want;
  } step_row_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [63:0]  s_axis_tdata = '0;
  logic [1:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [159:0] m_axis_tdata;
  logic         cfg_we = 1'b0;
  logic [2:0]   cfg_index = '0;
  logic [31:0]  cfg_data = '0;

  // predictor copy of the vehicle state and the start registers
  longint cur_x, cur_y, cur_speed, cur_heading, cur_accel, cur_steer;
  logic [31:0] start_regs [0:5];

  vehicle_state_t states_due [$];
  int  err_count = 0;
  bit  idle_on = 1'b1;
  bit  long_hold = 1'b0;
  int  quiet_cycles = 0;

  kinematic_bicycle_step_top i_dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  function automatic longint wrap_heading(input longint h);
    longint r;
    r = (h + HALF_TURN) % FULL_TURN;
    if (r < 0) r += FULL_TURN;
    return r - HALF_TURN;
  endfunction

  function automatic longint limit(input longint v, input longint lo, input longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // rotation-mode CORDIC, results in Q16
  task automatic rotate_cordic(input longint ang, output longint c, output longint s);
    longint x, y, z, dx, dy;
    bit flip;
    flip = 1'b0;
    z = ang;
    y = 0;
    if (z > QUARTER) begin
      z -= HALF_TURN; flip = 1'b1;
    end else if (z < -QUARTER) begin
      z += HALF_TURN; flip = 1'b1;
    end
    x = longint'(kbs_pkg::CORDIC_GAIN_Q30) >>> (30 - FRAC);
    for (int i = 0; i < ROT_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= ARC_TAB[i];
      end else begin
        x += dx; y -= dy; z += ARC_TAB[i];
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endtask

  // one Euler step over dt, all terms from the state before the step
  task automatic euler_advance(input longint dt);
    longint ch, sh, cs, ss, tn, dx, dy, dh, v, iwb;
    iwb = longint'(start_regs[5][17:0]);
    rotate_cordic(cur_heading, ch, sh);
    rotate_cordic(cur_steer * 256, cs, ss);
    if (cs <= 0) cs = 1;
    tn = (ss * 65536) / cs;
    dx = (((cur_speed * ch) >>> FRAC) * dt) >>> 16;
    dy = (((cur_speed * sh) >>> FRAC) * dt) >>> 16;
    dh = (((((cur_speed * tn) >>> FRAC) * iwb) >>> 16) * dt) >>> 8;
    v = cur_speed + ((cur_accel * dt) >>> 16);
    cur_x = limit(cur_x + dx, X_MIN, X_MAX);
    cur_y = limit(cur_y + dy, X_MIN, X_MAX);
    cur_heading = wrap_heading(cur_heading + dh);
    if (v <= 0) begin
      v = 0;
      if (cur_accel < 0) cur_accel = 0;
    end
    cur_speed = limit(v, 0, longint'(kbs_pkg::SPEED_MAX));
  endtask

  task automatic predict_state(input logic [1:0] act, input logic [16:0] dt,
                               input logic [21:0] acc, input logic [17:0] str,
                               output vehicle_state_t st);
    case (act)
      kbs_pkg::ACT_ADVANCE: euler_advance(longint'(dt));
      kbs_pkg::ACT_CONTROL: begin
        cur_accel = longint'($signed(acc));
        cur_steer = limit(longint'($signed(str)), -65536, 65536);
      end
      kbs_pkg::ACT_RESTART: begin
        cur_x = longint'($signed(start_regs[0]));
        cur_y = longint'($signed(start_regs[1]));
        cur_speed = limit(longint'(start_regs[2][22:0]), 0, longint'(kbs_pkg::SPEED_MAX));
        cur_heading = wrap_heading(longint'($signed(start_regs[3][26:0])));
        cur_accel = longint'($signed(start_regs[4][21:0]));
        cur_steer = 0;
      end
      default: ;
    endcase
    st.px = cur_x[31:0];
    st.py = cur_y[31:0];
    st.spd = cur_speed[22:0];
    st.hdg = cur_heading[26:0];
    st.acc = cur_accel[21:0];
    st.str = cur_steer[17:0];
  endtask

  task automatic mismatch_report(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h expected %h at %0t", field, got, want, $time);
    err_count++;
  endtask

  // offer one item and hold it until taken; returns at the accepting edge
  task automatic send_item(input logic [1:0] act, input logic [16:0] dt,
                           input logic [21:0] acc, input logic [17:0] str,
                           input bit known = 1'b0, input vehicle_state_t want = '{default: '0});
    vehicle_state_t st;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= act;
    s_axis_tdata <= {7'b0, str, acc, dt};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    predict_state(act, dt, acc, str, st);
    states_due.insert(states_due.size(), known ? want : st);
  endtask

  task automatic idle_input(input int n);
    s_axis_tvalid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // wait until every expected result has been taken
  task automatic drain();
    while (states_due.size() != 0) @(posedge clk);
  endtask

  // drain all results and let the block go quiet before touching registers
  task automatic settle();
    idle_input(1);
    drain();
    repeat (120) @(posedge clk);
  endtask

  task automatic load_start_regs(input logic [31:0] vals [0:5]);
    for (int i = 0; i < 6; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= 3'(i);
      cfg_data <= vals[i];
      case (3'(i))
        kbs_pkg::REG_START_X, kbs_pkg::REG_START_Y: start_regs[i] = vals[i];
        kbs_pkg::REG_START_SPEED:   start_regs[i] = vals[i] & 32'h7FFFFF;
        kbs_pkg::REG_START_HEADING: start_regs[i] = vals[i] & 32'h7FFFFFF;
        kbs_pkg::REG_START_ACCEL:   start_regs[i] = vals[i] & 32'h3FFFFF;
        default:                    start_regs[i] = vals[i] & 32'h3FFFF;
      endcase
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_start_regs();
    logic [31:0] v [0:5];
    v[0] = $urandom();
    v[1] = $urandom();
    v[2] = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 6553600);
    v[3] = $urandom();
    v[4] = ($urandom_range(0, 3) == 0) ? $urandom() : 32'(int'($urandom_range(0, 2621440)) - 1310720);
    v[5] = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(6554, 131072);
    load_start_regs(v);
  endtask

  // mostly advance and control runs after a restart, with some noise
  task automatic run_random(input int n, input bit gaps);
    int r;
    logic [16:0] dt;
    logic [21:0] acc;
    logic [17:0] str;
    send_item(kbs_pkg::ACT_RESTART, 17'($urandom()), 22'($urandom()), 18'($urandom()));
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      acc = ($urandom_range(0, 4) == 0) ? 22'($urandom())
                                        : 22'(int'($urandom_range(0, 2621440)) - 1310720);
      str = ($urandom_range(0, 4) == 0) ? 18'($urandom())
                                        : 18'(int'($urandom_range(0, 131072)) - 65536);
      case ($urandom_range(0, 9))
        0:       dt = 17'($urandom());
        1:       dt = 17'($urandom_range(0, 2047));
        default: dt = 17'($urandom_range(0, 65536));
      endcase
      if (r < 55)      send_item(kbs_pkg::ACT_ADVANCE, dt, acc, str);
      else if (r < 82) send_item(kbs_pkg::ACT_CONTROL, dt, acc, str);
      else if (r < 93) send_item(kbs_pkg::ACT_RESTART, dt, acc, str);
      else             send_item(ACT_UNUSED, dt, acc, str);
      if (gaps && $urandom_range(0, 4) == 0) idle_input($urandom_range(1, 19));
    end
  endtask

  // receiver readiness: random bursts, plus one long hold on request
  initial begin
    @(negedge rst);
    forever begin
      if (long_hold) begin
        m_axis_tready <= 1'b0;
        repeat (400) @(posedge clk);
        long_hold = 1'b0;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end else begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end
    end
  end

  // compare each taken result with the oldest expected state
  always @(posedge clk) begin
    vehicle_state_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (states_due.size() == 0) begin
        $display("unexpected result item at %0t", $time);
        err_count++;
      end else begin
        want = states_due.pop_front();
        if (m_axis_tdata[31:0] !== want.px) mismatch_report("pos_x", m_axis_tdata[31:0], want.px);
        if (m_axis_tdata[63:32] !== want.py)
          mismatch_report("pos_y", m_axis_tdata[63:32], want.py);
        if (m_axis_tdata[86:64] !== want.spd)
          mismatch_report("speed", 32'(m_axis_tdata[86:64]), 32'(want.spd));
        if (m_axis_tdata[113:87] !== want.hdg)
          mismatch_report("heading", 32'(m_axis_tdata[113:87]), 32'(want.hdg));
        if (m_axis_tdata[135:114] !== want.acc)
          mismatch_report("accel", 32'(m_axis_tdata[135:114]), 32'(want.acc));
        if (m_axis_tdata[153:136] !== want.str)
          mismatch_report("steer", 32'(m_axis_tdata[153:136]), 32'(want.str));
      end
    end
  end

  // watchdog on cycles with no item moving on either side
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    step_row_t rows [$];
    vehicle_state_t zero_st;
    vehicle_state_t held_st;
    logic [31:0] v [0:5];
    zero_st = '{default: '0};
    held_st = '{32'd0, 32'd0, 23'd0, 27'd0, 22'd0, -18'sd65536};
    start_regs = '{32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'(kbs_pkg::IWB_RESET)};
    cur_x = 0; cur_y = 0; cur_speed = 0; cur_heading = 0; cur_accel = 0; cur_steer = 0;

    // reset state, saturation of commands, speed floor, unused action code
    rows.insert(rows.size(), '{kbs_pkg::ACT_ADVANCE, 17'd65536, 22'd0, 18'd0, 1'b1, zero_st});
    rows.insert(rows.size(), '{kbs_pkg::ACT_RESTART, 17'h1FFFF, 22'h3FFFFF, 18'h3FFFF, 1'b1,
                               zero_st});
    rows.insert(rows.size(), '{kbs_pkg::ACT_CONTROL, 17'd0, 22'd1310720, 18'h1FFFF, 1'b1,
                     '{32'd0, 32'd0, 23'd0, 27'd0, 22'd1310720, 18'd65536}});
    rows.insert(rows.size(), '{kbs_pkg::ACT_CONTROL, 17'd5, -22'sd1310720, 18'h20000, 1'b1,
                     '{32'd0, 32'd0, 23'd0, 27'd0, -22'sd1310720, -18'sd65536}});
    rows.insert(rows.size(), '{kbs_pkg::ACT_ADVANCE, 17'd65536, 22'd0, 18'd0, 1'b1, held_st});
    rows.insert(rows.size(), '{ACT_UNUSED, 17'h1FFFF, 22'h2AAAAA, 18'h15555, 1'b1, held_st});
    rows.insert(rows.size(), '{kbs_pkg::ACT_CONTROL, 17'd0, 22'd1310720, 18'd0, 1'b1,
                     '{32'd0, 32'd0, 23'd0, 27'd0, 22'd1310720, 18'd0}});
    rows.insert(rows.size(), '{kbs_pkg::ACT_ADVANCE, 17'h1FFFF, 22'd0, 18'd0, 1'b0, zero_st});
    rows.insert(rows.size(), '{kbs_pkg::ACT_CONTROL, 17'd0, 22'h1FFFFF, 18'd65536, 1'b0,
                               zero_st});
    rows.insert(rows.size(), '{kbs_pkg::ACT_ADVANCE, 17'd65536, 22'd0, 18'd0, 1'b0, zero_st});
    rows.insert(rows.size(), '{kbs_pkg::ACT_ADVANCE, 17'd65536, 22'd0, 18'd0, 1'b0, zero_st});
    rows.insert(rows.size(), '{kbs_pkg::ACT_CONTROL, 17'd0, 22'd0, -18'sd65536, 1'b0,
                               zero_st});
    rows.insert(rows.size(), '{kbs_pkg::ACT_ADVANCE, 17'd0, 22'd0, 18'd0, 1'b0, zero_st});
    rows.insert(rows.size(), '{kbs_pkg::ACT_ADVANCE, 17'd65536, 22'd0, 18'd0, 1'b0, zero_st});
    rows.insert(rows.size(), '{kbs_pkg::ACT_ADVANCE, 17'd40000, 22'd0, 18'd0, 1'b0, zero_st});

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i]) begin
      send_item(rows[i].act, rows[i].dt, rows[i].acc, rows[i].str, rows[i].known, rows[i].want);
      if ($urandom_range(0, 2) == 0) idle_input($urandom_range(1, 19));
    end
    settle();

    // high extremes; the receiver holds off long so the block backs up
    v = '{32'h7FFFFFFF, 32'h80000000, 32'h7FFFFF, 32'h4000000, 32'h1FFFFF, 32'h3FFFF};
    load_start_regs(v);
    long_hold = 1'b1;
    run_random(60, 1'b1);
    settle();

    // low extremes; the sender pauses midway until all results are back
    v = '{32'h80000000, 32'h7FFFFFFF, 32'd6553600, 32'h3FFFFFF, 32'h2C0000, 32'd6554};
    load_start_regs(v);
    run_random(30, 1'b1);
    idle_input(1);
    drain();
    @(posedge clk);
    run_random(30, 1'b1);
    settle();

    repeat (3) begin
      random_start_regs();
      run_random(100, 1'b1);
      settle();
    end

    // closing stretch without idling on either side
    idle_on = 1'b0;
    random_start_regs();
    run_random(80, 1'b0);
    idle_input(1);
    drain();
    repeat (200) @(posedge clk);
    if (err_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
